[hdl/bpc_pkg.sv]
// ============================================================================
// bpc_pkg
// Shared types and constants for the barometric pressure compensation core.
// ============================================================================
package bpc_pkg;

    // Config register indexes (byte address = 4 * index)
    localparam int            CFG_AW          = 5;
    localparam logic [2:0]    CFG_SENS        = 3'd0;
    localparam logic [2:0]    CFG_OFFSET      = 3'd1;
    localparam logic [2:0]    CFG_SENS_TC     = 3'd2;
    localparam logic [2:0]    CFG_OFFSET_TC   = 3'd3;
    localparam logic [2:0]    CFG_TREF        = 3'd4;
    localparam logic [2:0]    CFG_TEMPSENS    = 3'd5;

    // Temperature thresholds, 0.01 C
    localparam logic signed [18:0] TEMP_REF   = 19'sd2000;
    localparam logic signed [18:0] TEMP_VLOW  = -19'sd1500;

    // Second-order weights
    localparam logic [39:0]   OFF2_A_MUL      = 40'd5;
    localparam logic [39:0]   OFF2_B_MUL      = 40'd7;
    localparam logic [39:0]   SENS2_B_MUL     = 40'd11;

    // Scaling shifts
    localparam int            SHIFT_TREF      = 8;
    localparam int            SHIFT_T         = 23;
    localparam int            SHIFT_OFF_C     = 16;
    localparam int            SHIFT_SENS_C    = 15;
    localparam int            SHIFT_OFF       = 7;
    localparam int            SHIFT_SENS      = 8;
    localparam int            SHIFT_SQ        = 31;
    localparam int            SENS_SPLIT      = 20;
    localparam int            SHIFT_P1        = 21;
    localparam int            SHIFT_P2        = 15;

    // Edges from accepted start to result strobe
    localparam int            LATENCY         = 8;

    typedef struct packed {
        logic [23:0] pressure_raw;
        logic [23:0] temperature_raw;
    } t_sample;

    typedef struct packed {
        logic signed [18:0] temperature_centi;
        logic signed [31:0] pressure_pascal;
    } t_result;

    typedef struct packed {
        logic [15:0] sens;
        logic [15:0] offset;
        logic [15:0] sens_tc;
        logic [15:0] offset_tc;
        logic [15:0] tref;
        logic [15:0] tempsens;
    } t_cfg;

    // First-order results
    typedef struct packed {
        logic               valid;
        logic [23:0]        d1;
        logic signed [18:0] temp1;
        logic [17:0]        t2;
        logic signed [39:0] off;
        logic signed [38:0] sens;
    } t_first;

    // After second-order correction
    typedef struct packed {
        logic               valid;
        logic [23:0]        d1;
        logic signed [18:0] temp;
        logic signed [39:0] off;
        logic signed [38:0] sens;
    } t_second;

endpackage

[hdl/bpc_regs.sv]
// ============================================================================
// bpc_regs
// APB register file holding the six calibration words.
// ============================================================================
module bpc_regs import bpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       n_wr;
    logic [2:0] n_idx;

    assign pready = 1'b1;
    assign n_wr   = psel && penable && pwrite;
    assign n_idx  = paddr[CFG_AW-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (n_wr) begin
            unique case (n_idx)
                CFG_SENS:      r_cfg.sens      <= pwdata[15:0];
                CFG_OFFSET:    r_cfg.offset    <= pwdata[15:0];
                CFG_SENS_TC:   r_cfg.sens_tc   <= pwdata[15:0];
                CFG_OFFSET_TC: r_cfg.offset_tc <= pwdata[15:0];
                CFG_TREF:      r_cfg.tref      <= pwdata[15:0];
                CFG_TEMPSENS:  r_cfg.tempsens  <= pwdata[15:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (n_idx)
            CFG_SENS:      prdata = {16'h0, r_cfg.sens};
            CFG_OFFSET:    prdata = {16'h0, r_cfg.offset};
            CFG_SENS_TC:   prdata = {16'h0, r_cfg.sens_tc};
            CFG_OFFSET_TC: prdata = {16'h0, r_cfg.offset_tc};
            CFG_TREF:      prdata = {16'h0, r_cfg.tref};
            CFG_TEMPSENS:  prdata = {16'h0, r_cfg.tempsens};
            default:       prdata = '0;
        endcase
    end

endmodule

[hdl/bpc_first.sv]
// ============================================================================
// bpc_first
// Stages 1-3: dT, the four dT products, first-order TEMP/OFF/SENS.
// ============================================================================
module bpc_first import bpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_first  o_first
);

    // stage 1
    logic               r_s1_valid;
    logic [23:0]        r_s1_d1;
    logic signed [24:0] r_s1_dt;
    logic signed [24:0] n_dt;

    // stage 2
    logic               r_s2_valid;
    logic [23:0]        r_s2_d1;
    logic signed [41:0] r_s2_pt;
    logic signed [41:0] r_s2_poff;
    logic signed [41:0] r_s2_psens;
    logic signed [49:0] r_s2_psq;

    // stage 3
    t_first             r_s3;
    t_first             n_s3;
    logic signed [41:0] n_tsh;
    logic signed [41:0] n_offsh;
    logic signed [41:0] n_senssh;
    logic signed [49:0] n_sqsh;

    assign n_dt = $signed({1'b0, i_sample.temperature_raw})
                - $signed({1'b0, i_cfg.tref, {SHIFT_TREF{1'b0}}});

    // stage 3 register: only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3.valid <= n_s3.valid;
        end
        r_s3.d1    <= n_s3.d1;
        r_s3.temp1 <= n_s3.temp1;
        r_s3.t2    <= n_s3.t2;
        r_s3.off   <= n_s3.off;
        r_s3.sens  <= n_s3.sens;
    end

    always_ff @(posedge i_clk) begin
        r_s1_d1    <= i_sample.pressure_raw;
        r_s1_dt    <= n_dt;
        r_s2_d1    <= r_s1_d1;
        r_s2_pt    <= r_s1_dt * $signed({1'b0, i_cfg.tempsens});
        r_s2_poff  <= r_s1_dt * $signed({1'b0, i_cfg.offset_tc});
        r_s2_psens <= r_s1_dt * $signed({1'b0, i_cfg.sens_tc});
        r_s2_psq   <= r_s1_dt * r_s1_dt;
    end

    always_comb begin
        n_tsh      = r_s2_pt    >>> SHIFT_T;
        n_offsh    = r_s2_poff  >>> SHIFT_OFF;
        n_senssh   = r_s2_psens >>> SHIFT_SENS;
        n_sqsh     = r_s2_psq   >>> SHIFT_SQ;
        n_s3.valid = r_s2_valid;
        n_s3.d1    = r_s2_d1;
        n_s3.temp1 = TEMP_REF + 19'(n_tsh);
        n_s3.t2    = 18'(n_sqsh);
        n_s3.off   = $signed({8'h0, i_cfg.offset, {SHIFT_OFF_C{1'b0}}}) + 40'(n_offsh);
        n_s3.sens  = $signed({8'h0, i_cfg.sens, {SHIFT_SENS_C{1'b0}}}) + 39'(n_senssh);
    end

    assign o_first = r_s3;

endmodule

[hdl/bpc_second.sv]
// ============================================================================
// bpc_second
// Stages 4-5: second-order corrections below 20.00 C and below -15.00 C.
// ============================================================================
module bpc_second import bpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_first  i_first,
    output t_second o_second
);

    // stage 4: squares
    logic               r_valid;
    logic [23:0]        r_d1;
    logic signed [18:0] r_temp1;
    logic [17:0]        r_t2;
    logic signed [39:0] r_off;
    logic signed [38:0] r_sens;
    logic               r_low;
    logic               r_vlow;
    logic [35:0]        r_aa;
    logic [35:0]        r_bb;
    logic signed [19:0] n_a;
    logic signed [19:0] n_b;
    logic signed [39:0] n_aa;
    logic signed [39:0] n_bb;

    // stage 5
    t_second            r_s5;
    logic [39:0]        n_aa5;
    logic [39:0]        n_bb7;
    logic [39:0]        n_bb11;
    logic [39:0]        n_off2;
    logic [39:0]        n_sens2;
    logic signed [39:0] n_sens40;

    assign n_a  = 20'(i_first.temp1) - 20'(TEMP_REF);
    assign n_b  = 20'(i_first.temp1) - 20'(TEMP_VLOW);
    assign n_aa = n_a * n_a;
    assign n_bb = n_b * n_b;

    // stage 5 register: only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_s5.valid <= 1'b0;
        end else begin
            r_valid    <= i_first.valid;
            r_s5.valid <= r_valid;
        end
        r_s5.d1   <= r_d1;
        r_s5.temp <= r_low ? (r_temp1 - $signed({1'b0, r_t2})) : r_temp1;
        r_s5.off  <= r_off - $signed(n_off2);
        r_s5.sens <= 39'(n_sens40);
    end

    always_ff @(posedge i_clk) begin
        r_d1    <= i_first.d1;
        r_temp1 <= i_first.temp1;
        r_t2    <= i_first.t2;
        r_off   <= i_first.off;
        r_sens  <= i_first.sens;
        r_low   <= i_first.temp1 < TEMP_REF;
        r_vlow  <= i_first.temp1 < TEMP_VLOW;
        r_aa    <= 36'(n_aa);
        r_bb    <= 36'(n_bb);
    end

    // squares are non-negative, so the divides are plain shifts
    always_comb begin
        n_aa5    = 40'(r_aa) * OFF2_A_MUL;
        n_bb7    = 40'(r_bb) * OFF2_B_MUL;
        n_bb11   = 40'(r_bb) * SENS2_B_MUL;
        n_off2   = (r_low  ? (n_aa5 >> 1) : '0) + (r_vlow ? n_bb7 : '0);
        n_sens2  = (r_low  ? (n_aa5 >> 2) : '0) + (r_vlow ? (n_bb11 >> 1) : '0);
        n_sens40 = 40'(r_sens) - $signed(n_sens2);
    end

    assign o_second = r_s5;

endmodule

[hdl/bpc_pres.sv]
// ============================================================================
// bpc_pres
// Stages 6-8: D1*SENS as two partial products, then the final scaling.
// ============================================================================
module bpc_pres import bpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_second i_second,
    output t_result o_result,
    output logic    o_valid
);

    // stage 6
    logic               r_s6_valid;
    logic signed [18:0] r_s6_temp;
    logic signed [39:0] r_s6_off;
    logic [43:0]        r_s6_lo;
    logic signed [43:0] r_s6_hi;

    // stage 7
    logic               r_s7_valid;
    logic signed [18:0] r_s7_temp;
    logic signed [39:0] r_s7_off;
    logic signed [42:0] r_s7_q;
    logic signed [63:0] n_prod;
    logic signed [63:0] n_q;

    // stage 8
    logic               r_s8_valid;
    t_result            r_s8;
    logic signed [43:0] n_diff;
    logic signed [43:0] n_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
            r_s8_valid <= 1'b0;
        end else begin
            r_s6_valid <= i_second.valid;
            r_s7_valid <= r_s6_valid;
            r_s8_valid <= r_s7_valid;
        end
    end

    always_comb begin
        n_prod = (64'(r_s6_hi) <<< SENS_SPLIT) + $signed(64'(r_s6_lo));
        n_q    = n_prod >>> SHIFT_P1;
        n_diff = 44'(r_s7_q) - 44'(r_s7_off);
        n_p    = n_diff >>> SHIFT_P2;
    end

    always_ff @(posedge i_clk) begin
        r_s6_temp <= i_second.temp;
        r_s6_off  <= i_second.off;
        r_s6_lo   <= i_second.d1 * i_second.sens[SENS_SPLIT-1:0];
        r_s6_hi   <= $signed({1'b0, i_second.d1}) * $signed(i_second.sens[38:SENS_SPLIT]);
        r_s7_temp <= r_s6_temp;
        r_s7_off  <= r_s6_off;
        r_s7_q    <= 43'(n_q);
        r_s8.temperature_centi <= r_s7_temp;
        r_s8.pressure_pascal   <= 32'(n_p);
    end

    assign o_result = r_s8;
    assign o_valid  = r_s8_valid;

endmodule

[hdl/baro_pressure_compensation_core.sv]
// ============================================================================
// baro_pressure_compensation_core
// Second-order barometric compensation: raw D1/D2 conversions plus six
// calibration words give temperature (0.01 C) and pressure (Pa).
// ============================================================================
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------
//  sample    | in        | start && !busy            | i_sample (t_sample)
//  result    | out       | o_result_valid strobe     | o_result (t_result)
//  config    | in/out    | APB, write on psel&penable| pwdata[15:0], 6 words @ 4*i
//            |           | &pwrite&pready            |
//
//  Eight-stage pipeline: an accepted transfer raises its result strobe once it
//  has been registered through stages 1 to 8, and the receiver takes it then.
//  A new sample may enter every cycle.
//  busy is tied low; there is no stall on either side (the receiver
//  takes each result in its single strobe cycle).
//  Synchronous active-low reset clears the valid bits and the calibration
//  words; datapath registers are not reset.
//  Depth is set by the D1*SENS product, split into two partial products.
//
module baro_pressure_compensation_core import bpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample channel
    input  logic              start,
    output logic              busy,
    input  t_sample           i_sample,
    // result channel
    output t_result           o_result,
    output logic              o_result_valid,
    // APB config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg    w_cfg;
    t_first  w_first;
    t_second w_second;
    logic    w_accept;

    // fully pipelined, never backs off the sender
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    bpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // stages 1-3: dT = D2 - C5*2^8, products with dT, first-order terms
    bpc_first u_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_sample (i_sample),
        .i_cfg    (w_cfg),
        .o_first  (w_first)
    );

    // stages 4-5: low / very-low temperature corrections
    bpc_second u_second (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_first  (w_first),
        .o_second (w_second)
    );

    // stages 6-8: P = ((D1*SENS >> 21) - OFF) >> 15
    bpc_pres u_pres (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_second (w_second),
        .o_result (o_result),
        .o_valid  (o_result_valid)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // every strobe comes from an earlier accepted sample transfer
    a_strobe_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(w_accept, LATENCY))
        else $error("result strobe without matching sample transfer");

    // every accepted transfer later yields a strobe
    a_transfer_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_result_valid)
        else $error("sample transfer lost in pipeline");

    // writes to unmapped addresses leave the calibration words alone
    a_unmapped_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite &&
         (paddr[CFG_AW-1:2] == 3'd6 || paddr[CFG_AW-1:2] == 3'd7))
        |=> $stable(w_cfg))
        else $error("unmapped write changed calibration");

endmodule
